// File: design/eg_pkg.sv
// ----------------------------------------------------------------------------
// eg_pkg: shared types and constants for the modular-exponent encryption block
// Holds the data width, register indexes, payload structs and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package eg_pkg;

	localparam int WIDTH = 16;
	localparam int CNT_W = $clog2(WIDTH + 1);

	typedef logic [WIDTH-1:0] word_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_MODULUS   = 2'd0;
	localparam logic [1:0] REG_GENERATOR = 2'd1;
	localparam logic [1:0] REG_KEY       = 2'd2;

	localparam word_t RST_MODULUS   = word_t'(65521);
	localparam word_t RST_GENERATOR = word_t'(2);
	localparam word_t RST_KEY       = word_t'(1);

	typedef struct packed {
		word_t message;
		word_t ephemeral_exp;
	} in_item_t;

	typedef struct packed {
		word_t public_key;
		word_t cipher_first;
		word_t cipher_second;
		word_t recovered;
		logic  key_invalid;
	} out_item_t;

	// Datapath operations.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,     // latch inputs, start reducing g and m
		OP_RED_G,    // one restoring step of g mod p
		OP_RED_M,    // one restoring step of m mod p
		OP_EXP_INIT, // set r=1, base, exponent from selector
		OP_EXP_MUL,  // start r*base
		OP_EXP_SQR,  // start base*base
		OP_EXP_SAVE, // store r into selected result
		OP_MUL_STEP, // one shift-add step of the modular multiplier
		OP_FIN_MUL,  // start final product (c2 or rec)
		OP_FIN_SAVE, // store final product
		OP_OUT       // copy the finished result into the output register
	} op_t;

	typedef enum logic [1:0] {
		SEL_Y,
		SEL_C1,
		SEL_YB,
		SEL_GAMMA
	} sel_t;

	typedef struct packed {
		op_t  op;
		sel_t sel;
		logic fin_rec; // final multiply targets recovered (else c2)
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic exp_done;
		logic exp_bit;
		logic red_done;
		logic invalid;
	} dp_sts_t;

endpackage

// File: design/eg_datapath.sv
// ----------------------------------------------------------------------------
// eg_datapath: registers, modular multiplier and exponent bookkeeping
// Executes one command per cycle from the controller and reports status.
// ----------------------------------------------------------------------------
module eg_datapath import eg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	input  in_item_t  in_item,
	input  word_t     modulus,
	input  word_t     generator,
	input  word_t     private_key,
	output dp_sts_t   sts,
	output out_item_t res
);

	word_t              g_q, m_q, b_q;
	word_t              r_q, base_q, e_q;
	word_t              y_q, c1_q, yb_q, gam_q, c2_q, rec_q;
	word_t              mx_q, my_q, acc_q;
	logic [2*WIDTH-1:0] rd_q;   // shifted modulus for reduction
	logic [CNT_W-1:0]   rcnt_q;
	logic [CNT_W-1:0]   mcnt_q;
	logic               inv_q;
	logic               mul_for_r_q;
	logic               mul_base_q;
	out_item_t          out_q;

	// Modular add of two values below p, one extra bit for the carry.
	function automatic word_t add_mod(word_t a, word_t b, word_t p);
		logic [WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, p})
			s = s - {1'b0, p};
		return s[WIDTH-1:0];
	endfunction

	logic  invalid;
	word_t pm1;
	assign pm1 = modulus - word_t'(1);
	assign invalid = (modulus < word_t'(3)) || (private_key >= pm1);

	// Operand for the reduction step, from command.
	word_t              rval;
	logic [2*WIDTH-1:0] rval_ext;
	always_comb begin
		if (cmd.op == OP_RED_M)
			rval = m_q;
		else
			rval = g_q;
		rval_ext = {{WIDTH{1'b0}}, rval};
	end

	// Accumulator value after the current multiplier step.
	word_t prod_next;
	assign prod_next = my_q[0] ? add_mod(acc_q, mx_q, modulus) : acc_q;

	// Result fields, zeroed when the key or modulus is unusable.
	out_item_t res_next;
	always_comb begin
		res_next.public_key    = inv_q ? '0 : y_q;
		res_next.cipher_first  = inv_q ? '0 : c1_q;
		res_next.cipher_second = inv_q ? '0 : c2_q;
		res_next.recovered     = inv_q ? '0 : rec_q;
		res_next.key_invalid   = inv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q         <= '0;
			m_q         <= '0;
			b_q         <= '0;
			r_q         <= '0;
			base_q      <= '0;
			e_q         <= '0;
			y_q         <= '0;
			c1_q        <= '0;
			yb_q        <= '0;
			gam_q       <= '0;
			c2_q        <= '0;
			rec_q       <= '0;
			mx_q        <= '0;
			my_q        <= '0;
			acc_q       <= '0;
			rd_q        <= '0;
			rcnt_q      <= '0;
			mcnt_q      <= '0;
			inv_q       <= 1'b0;
			mul_for_r_q <= 1'b0;
			mul_base_q  <= 1'b0;
			out_q       <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					g_q    <= generator;
					m_q    <= in_item.message;
					b_q    <= in_item.ephemeral_exp;
					inv_q  <= invalid;
					rd_q   <= {1'b0, modulus, {(WIDTH-1){1'b0}}};
					rcnt_q <= CNT_W'(WIDTH);
				end
				OP_RED_G, OP_RED_M: begin
					// Restoring remainder: subtract p<<k where it fits, then rearm.
					if (rcnt_q != CNT_W'(0)) begin
						if (rval_ext >= rd_q) begin
							if (cmd.op == OP_RED_M)
								m_q <= word_t'(rval_ext - rd_q);
							else
								g_q <= word_t'(rval_ext - rd_q);
						end
						rd_q   <= rd_q >> 1;
						rcnt_q <= rcnt_q - CNT_W'(1);
					end else begin
						rd_q   <= {1'b0, modulus, {(WIDTH-1){1'b0}}};
						rcnt_q <= CNT_W'(WIDTH);
					end
				end
				OP_EXP_INIT: begin
					r_q <= word_t'(1);
					case (cmd.sel)
						SEL_Y:  begin base_q <= g_q;  e_q <= private_key; end
						SEL_C1: begin base_q <= g_q;  e_q <= b_q; end
						SEL_YB: begin base_q <= y_q;  e_q <= b_q; end
						SEL_GAMMA: begin
							base_q <= c1_q;
							e_q    <= pm1 - private_key;
						end
						default: begin base_q <= g_q; e_q <= '0; end
					endcase
				end
				OP_EXP_MUL: begin
					mx_q <= base_q; my_q <= r_q; acc_q <= '0;
					mcnt_q <= CNT_W'(WIDTH);
					mul_for_r_q <= 1'b1;
					mul_base_q  <= 1'b0;
				end
				OP_EXP_SQR: begin
					mx_q <= base_q; my_q <= base_q; acc_q <= '0;
					mcnt_q <= CNT_W'(WIDTH);
					e_q <= e_q >> 1;
					mul_for_r_q <= 1'b0;
					mul_base_q  <= 1'b1;
				end
				OP_FIN_MUL: begin
					mcnt_q <= CNT_W'(WIDTH);
					acc_q  <= '0;
					mul_for_r_q <= 1'b0;
					mul_base_q  <= 1'b0;
					if (cmd.fin_rec) begin mx_q <= gam_q; my_q <= c2_q; end
					else begin mx_q <= m_q; my_q <= yb_q; end
				end
				OP_MUL_STEP: begin
					// The last step also writes the product back to r or base, if it is for one of them.
					if (mcnt_q != CNT_W'(0)) begin
						acc_q  <= prod_next;
						mx_q   <= add_mod(mx_q, mx_q, modulus);
						my_q   <= my_q >> 1;
						mcnt_q <= mcnt_q - CNT_W'(1);
						if (mcnt_q == CNT_W'(1)) begin
							if (mul_for_r_q)
								r_q <= prod_next;
							else if (mul_base_q)
								base_q <= prod_next;
						end
					end
				end
				OP_EXP_SAVE: begin
					case (cmd.sel)
						SEL_Y:   y_q   <= r_q;
						SEL_C1:  c1_q  <= r_q;
						SEL_YB:  yb_q  <= r_q;
						default: gam_q <= r_q;
					endcase
				end
				OP_FIN_SAVE: begin
					if (cmd.fin_rec) rec_q <= acc_q;
					else c2_q <= acc_q;
				end
				OP_OUT: out_q <= res_next;
				default: ;
			endcase
		end
	end

	assign sts.mul_done = (mcnt_q == CNT_W'(0));
	assign sts.exp_done = (e_q == '0);
	assign sts.exp_bit  = e_q[0];
	assign sts.red_done = (rcnt_q == CNT_W'(0));
	assign sts.invalid  = inv_q;

	assign res = out_q;

endmodule

// File: design/eg_ctrl.sv
// ----------------------------------------------------------------------------
// eg_ctrl: sequencer for the four exponentiations and two products
// Issues datapath commands and runs the valid/ready handshakes.
// ----------------------------------------------------------------------------
module eg_ctrl import eg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_RED_G, S_RED_M, S_INIT, S_CHECK, S_MUL, S_MUL_RUN,
		S_SQR, S_SQR_RUN, S_SAVE, S_FIN, S_FIN_RUN, S_FIN_SAVE, S_OUT
	} state_t;

	state_t state_q;
	sel_t   sel_q;
	logic   fin_q;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new result when empty or being read.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode from the current state.
	always_comb begin
		cmd.sel     = sel_q;
		cmd.fin_rec = fin_q;
		case (state_q)
			S_IDLE:    cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_RED_G:   cmd.op = OP_RED_G;
			S_RED_M:   cmd.op = OP_RED_M;
			S_INIT:    cmd.op = OP_EXP_INIT;
			S_MUL:     cmd.op = OP_EXP_MUL;
			S_SQR:     cmd.op = OP_EXP_SQR;
			S_MUL_RUN, S_SQR_RUN, S_FIN_RUN: cmd.op = OP_MUL_STEP;
			S_SAVE:    cmd.op = OP_EXP_SAVE;
			S_FIN:     cmd.op = OP_FIN_MUL;
			S_FIN_SAVE: cmd.op = OP_FIN_SAVE;
			S_OUT:     cmd.op = out_free ? OP_OUT : OP_NONE;
			default:   cmd.op = OP_NONE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= SEL_Y;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (state_q == S_OUT && out_free) ? 1'b1
				: (out_valid_q && !out_ready);
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_RED_G;
				S_RED_G: if (sts.invalid) state_q <= S_OUT;
					else if (sts.red_done) state_q <= S_RED_M;
				S_RED_M: if (sts.red_done) begin
					state_q <= S_INIT;
					sel_q   <= SEL_Y;
				end
				S_INIT: state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.exp_done) state_q <= S_SAVE;
					else if (sts.exp_bit) state_q <= S_MUL;
					else state_q <= S_SQR;
				end
				S_MUL: state_q <= S_MUL_RUN;
				S_MUL_RUN: if (sts.mul_done) state_q <= S_SQR;
				S_SQR: state_q <= S_SQR_RUN;
				S_SQR_RUN: if (sts.mul_done) state_q <= S_CHECK;
				S_SAVE: begin
					case (sel_q)
						SEL_Y:  begin sel_q <= SEL_C1; state_q <= S_INIT; end
						SEL_C1: begin sel_q <= SEL_YB; state_q <= S_INIT; end
						SEL_YB: begin fin_q <= 1'b0; state_q <= S_FIN; end
						default: begin fin_q <= 1'b1; state_q <= S_FIN; end
					endcase
				end
				S_FIN: state_q <= S_FIN_RUN;
				S_FIN_RUN: if (sts.mul_done) state_q <= S_FIN_SAVE;
				S_FIN_SAVE: begin
					if (fin_q) state_q <= S_OUT;
					else begin sel_q <= SEL_GAMMA; state_q <= S_INIT; end
				end
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> (!out_valid || out_ready))
		else $error("result overwritten");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_RED_G) else $error("item lost");

endmodule

// File: design/elgamal_encrypt_decrypt.sv
// ----------------------------------------------------------------------------
// elgamal_encrypt_decrypt: ElGamal encryption and decryption modulo p
// Top level joining the sequencer, the datapath and the config registers.
// ----------------------------------------------------------------------------
// One item at a time. The item is latched when accepted; g and m are then
// reduced mod p, followed by four square-and-multiply exponentiations and
// two products on a shared bit-serial modular multiplier. An item finishes
// sooner when the exponents have fewer set bits. The finished result goes
// into an output register, and the next item is accepted while it waits; a
// new result waits only if the previous one is still unread. An invalid key
// or modulus gives its all-zero result with key_invalid set, without running
// the exponentiations. Registers must not be written while an item is in
// flight.
module elgamal_encrypt_decrypt import eg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [1:0] cfg_index,
	input  word_t     cfg_wdata
);

	word_t   modulus_q, generator_q, key_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= RST_MODULUS;
			generator_q <= RST_GENERATOR;
			key_q       <= RST_KEY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULUS:   modulus_q   <= cfg_wdata;
				REG_GENERATOR: generator_q <= cfg_wdata;
				REG_KEY:       key_q       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	eg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	eg_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_item(in_data),
		.modulus(modulus_q), .generator(generator_q), .private_key(key_q),
		.sts(sts), .res(out_data)
	);

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the ElGamal encryption and decryption block
// Drives message/exponent items through a valid/ready channel, writes the
// modulus, generator and key registers between phases, and compares every
// result against a bit-accurate predictor, queued in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb;
	import eg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 4_000_000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_we;
	logic [1:0] cfg_index;
	word_t     cfg_wdata;

	// Shadow copy of the configuration registers.
	word_t cur_mod;
	word_t cur_gen;
	word_t cur_key;

	// Modular arithmetic helpers for the predictor.
	function automatic word_t mod_mul(word_t x, word_t y, word_t m);
		logic [2*WIDTH-1:0] prod;
		prod = x * y;
		return word_t'(prod % m);
	endfunction

	function automatic word_t mod_pow(word_t base, word_t e, word_t m);
		word_t r;
		r = word_t'(1);
		for (int i = 0; i < WIDTH; i++) begin
			if (e[i])
				r = mod_mul(r, base, m);
			base = mod_mul(base, base, m);
		end
		return r;
	endfunction

	// Works out the result that one input item should produce.
	function automatic out_item_t encrypt_predict(in_item_t it, word_t p, word_t g0,
			word_t key);
		out_item_t o;
		word_t g, m, c1, c2, gam;
		o = '0;
		if (p < 3 || key >= p - 1) begin
			o.key_invalid = 1'b1;
			return o;
		end
		g = g0 % p;
		m = it.message % p;
		o.public_key = mod_pow(g, key, p);
		c1 = mod_pow(g, it.ephemeral_exp, p);
		c2 = mod_mul(m, mod_pow(o.public_key, it.ephemeral_exp, p), p);
		gam = mod_pow(c1, word_t'(p - 1 - key), p);
		o.cipher_first = c1;
		o.cipher_second = c2;
		o.recovered = mod_mul(gam, c2, p);
		return o;
	endfunction

	class cipher_board;
		out_item_t pending[$];
		int errors;
		int checked;
		int invalid_seen;

		function void note_item(in_item_t it, word_t p, word_t g, word_t key);
			pending.push_back(encrypt_predict(it, p, g, key));
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (want.key_invalid)
				invalid_seen++;
			if (got.public_key !== want.public_key) begin
				$display("%0t: public_key expected %h actual %h", $time,
					want.public_key, got.public_key);
				errors++;
			end
			if (got.cipher_first !== want.cipher_first) begin
				$display("%0t: cipher_first expected %h actual %h", $time,
					want.cipher_first, got.cipher_first);
				errors++;
			end
			if (got.cipher_second !== want.cipher_second) begin
				$display("%0t: cipher_second expected %h actual %h", $time,
					want.cipher_second, got.cipher_second);
				errors++;
			end
			if (got.recovered !== want.recovered) begin
				$display("%0t: recovered expected %h actual %h", $time,
					want.recovered, got.recovered);
				errors++;
			end
			if (got.key_invalid !== want.key_invalid) begin
				$display("%0t: key_invalid expected %b actual %b", $time,
					want.key_invalid, got.key_invalid);
				errors++;
			end
		endfunction
	endclass

	cipher_board board;
	int cycle_count;
	bit no_idle;
	int items_sent;

	elgamal_encrypt_decrypt dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: random stalls, check at each accepted item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_result(out_data);
			out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 32);
		end
	end

	// Sends one item, with a random gap beforehand. Valid stays high after
	// acceptance only until the next call or a drain, within the same step.
	task automatic send_item(word_t msg, word_t e);
		in_item_t it;
		it.message = msg;
		it.ephemeral_exp = e;
		if (!no_idle && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (!no_idle && $urandom_range(99) < 32)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_item(it, cur_mod, cur_gen, cur_key);
		items_sent++;
	endtask

	// Waits until every expected item has arrived, plus some settling cycles.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Drives one register write; the caller lowers the write enable.
	task automatic write_reg(logic [1:0] idx, word_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_MODULUS)
			cur_mod = val;
		else if (idx == REG_GENERATOR)
			cur_gen = val;
		else if (idx == REG_KEY)
			cur_key = val;
	endtask

	task automatic set_config(word_t p, word_t g, word_t key);
		drain();
		write_reg(REG_MODULUS, p);
		write_reg(REG_GENERATOR, g);
		write_reg(REG_KEY, key);
		cfg_we <= 1'b0;
	endtask

	// Primes used for the random phases, small ones and the extremes.
	word_t primes[8] = '{16'd3, 16'd5, 16'd17, 16'd251, 16'd4099, 16'd30011,
		16'd65519, 16'd65521};

	initial begin
		word_t p;
		board = new();
		cycle_count = 0;
		items_sent = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODULUS;
		cfg_wdata = '0;
		cur_mod = RST_MODULUS;
		cur_gen = RST_GENERATOR;
		cur_key = RST_KEY;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, field extremes.
		send_item(16'd0, 16'd0);
		send_item(16'hFFFF, 16'hFFFF);
		send_item(16'd65521, 16'd1);
		send_item(16'd12345, 16'd65520);
		// Generator and message above p, key at p-2.
		set_config(16'd17, 16'hFFFF, 16'd15);
		send_item(16'd17, 16'd3);
		send_item(16'hFFFF, 16'd0);
		// Generator reducing to zero.
		set_config(16'd17, 16'd34, 16'd2);
		send_item(16'd5, 16'd0);
		send_item(16'd5, 16'd7);
		// Key of p-1 and above: flagged.
		set_config(16'd17, 16'd3, 16'd16);
		send_item(16'd9, 16'd9);
		set_config(16'd17, 16'd3, 16'hFFFE);
		send_item(16'd1, 16'd1);
		// Modulus too small.
		set_config(16'd2, 16'd1, 16'd1);
		send_item(16'd1, 16'd1);
		set_config(16'd0, 16'd1, 16'd1);
		send_item(16'd1, 16'd1);
		// Non-prime modulus and the largest modulus.
		set_config(16'd15, 16'd2, 16'd3);
		send_item(16'd7, 16'd5);
		set_config(16'hFFFF, 16'hFFFE, 16'hFFFC);
		send_item(16'hFFFE, 16'hAAAA);
		send_item(16'h5555, 16'h5555);
		// Smallest modulus.
		set_config(16'd3, 16'd2, 16'd1);
		send_item(16'd2, 16'd2);
		// Write to an unused register index is ignored.
		drain();
		write_reg(2'd3, 16'h1234);
		cfg_we <= 1'b0;
		send_item(16'd1, 16'd3);

		// Random phases; one phase with no idling on either side.
		for (int ph = 0; ph < 12; ph++) begin
			p = primes[$urandom_range(7)];
			if ($urandom_range(9) == 0)
				set_config(word_t'($urandom_range(65535)), word_t'($urandom),
					word_t'($urandom));
			else
				set_config(p, word_t'($urandom_range(p - 1, 1)),
					word_t'($urandom_range(p - 2, 1)));
			no_idle = (ph == 5);
			for (int k = 0; k < 19; k++)
				send_item(word_t'($urandom), word_t'($urandom));
		end
		no_idle = 1'b0;

		drain();
		$display("%0d items sent, %0d results checked (%0d flagged invalid),",
			items_sent, board.checked, board.invalid_seen);
		$display("across directed corner settings and 12 random register settings.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
